/* rtl/core/hrhp_pkg.sv */
// hrhp_pkg: types, codes and byte constants shared by the response head parser
// used by hrhp_ctrl, hrhp_datapath and http_response_head_parser
package hrhp_pkg;

   typedef enum logic [2:0] {
      PH_VERSION = 3'd0,
      PH_STATUS  = 3'd1,
      PH_REASON  = 3'd2,
      PH_HNAME   = 3'd3,
      PH_HVALUE  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUNNING   = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_MALFORMED = 3'd2,
      ST_CONN_ERR  = 3'd3,
      ST_OVERFLOW  = 3'd4
   } msg_status_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NUL   = 8'h00;

   typedef struct packed {
      logic step;
      logic flush_load;
      logic last_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic flush_needed;
      logic flush_last;
   } dp_status_type;

endpackage

/* rtl/core/hrhp_ctrl.sv */
// hrhp_ctrl: sequencer for the response head parser (accept, flush held bytes, emit last)
// depends on hrhp_pkg for the command and status structs
module hrhp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  hrhp_pkg::dp_status_type dp_status,
   output hrhp_pkg::ctrl_cmd_type  dp_cmd
);
   import hrhp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FLUSH = 3'b010,
      S_LAST  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in          = state_ff;
      dp_cmd.step       = 1'b0;
      dp_cmd.flush_load = 1'b0;
      dp_cmd.last_load  = 1'b0;
      req_tready        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = dp_status.out_free;
            if (req_tvalid && dp_status.out_free) begin
               dp_cmd.step = 1'b1;
               if (dp_status.flush_needed) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (dp_status.out_free) begin
               dp_cmd.flush_load = 1'b1;
               if (dp_status.flush_last) begin
                  state_in = S_LAST;
               end
            end
         end
         S_LAST: begin
            if (dp_status.out_free) begin
               dp_cmd.last_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/hrhp_datapath.sv */
// hrhp_datapath: parse state, whitespace hold memory and result register
// depends on hrhp_pkg; driven by hrhp_ctrl commands
module hrhp_datapath #(
   parameter int HOLD_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              in_byte,
   input  logic                    conn_error,
   input  hrhp_pkg::ctrl_cmd_type   dp_cmd,
   output hrhp_pkg::dp_status_type  dp_status,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [7:0]              rsp_byte,
   output logic [2:0]              rsp_kind,
   output logic                    rsp_content,
   output logic                    rsp_end,
   output logic [2:0]              rsp_status,
   output logic                    rsp_last
);
   import hrhp_pkg::*;

   localparam int CMAX = (HOLD_DEPTH > 2) ? HOLD_DEPTH : 2;
   localparam int CW   = $clog2(CMAX + 1);
   localparam int AW   = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

   phase_type      phase_ff, phase_in;
   logic [7:0]     prev_ff, prev_in;
   logic           seen_ff, seen_in;
   logic [CW-1:0]  held_ff, held_in;

   logic [7:0]     hold_mem [HOLD_DEPTH];
   logic [7:0]     rd_data_ff;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;

   logic [AW-1:0]  flush_idx_ff;
   logic [AW-1:0]  flush_end_ff;
   logic [7:0]     pend_byte_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff;
   logic [2:0]     rsp_kind_ff;
   logic           rsp_content_ff;
   logic           rsp_end_ff;
   logic [2:0]     rsp_status_ff;
   logic           rsp_last_ff;

   logic           is_white;
   logic           single;
   logic           flush_needed;
   logic           close_w;
   logic           content_w;
   msg_status_type status_w;

   assign is_white = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));

   always_comb begin
      status_w     = ST_RUNNING;
      close_w      = 1'b0;
      content_w    = 1'b0;
      wr_en        = 1'b0;
      flush_needed = 1'b0;
      phase_in     = phase_ff;
      prev_in      = in_byte;
      seen_in      = seen_ff;
      held_in      = held_ff;
      priority if (conn_error) begin
         status_w = ST_CONN_ERR;
      end else if (in_byte == CH_NUL) begin
         status_w = ST_MALFORMED;
      end else if ((in_byte == CH_SPACE) &&
                   ((phase_ff == PH_VERSION) || (phase_ff == PH_STATUS))) begin
         close_w = 1'b1;
      end else if ((in_byte == CH_COLON) && (phase_ff == PH_HNAME)) begin
         close_w = 1'b1;
      end else if ((in_byte == CH_LF) && (prev_ff == CH_CR)) begin
         if ((phase_ff == PH_REASON) || (phase_ff == PH_HVALUE)) begin
            close_w = 1'b1;
         end else if ((phase_ff == PH_HNAME) && !seen_ff && (held_ff == CW'(1))) begin
            status_w = ST_COMPLETE;
         end else begin
            status_w = ST_MALFORMED;
         end
      end else if (is_white) begin
         if (seen_ff) begin
            if (held_ff >= CW'(HOLD_DEPTH)) begin
               status_w = ST_OVERFLOW;
            end else begin
               wr_en   = 1'b1;
               held_in = held_ff + CW'(1);
            end
         end else if (held_ff < CW'(2)) begin
            held_in = held_ff + CW'(1);
         end
      end else begin
         content_w    = 1'b1;
         flush_needed = seen_ff && (held_ff != '0);
         held_in      = '0;
         seen_in      = 1'b1;
      end

      if (status_w != ST_RUNNING) begin
         phase_in = PH_VERSION;
         prev_in  = CH_NUL;
         seen_in  = 1'b0;
         held_in  = '0;
      end else if (close_w) begin
         unique case (phase_ff)
            PH_VERSION: phase_in = PH_STATUS;
            PH_STATUS:  phase_in = PH_REASON;
            PH_HNAME:   phase_in = PH_HVALUE;
            default:    phase_in = PH_HNAME;
         endcase
         seen_in = 1'b0;
         held_in = '0;
      end
   end

   assign single = (status_w != ST_RUNNING) || close_w || (content_w && !flush_needed);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VERSION;
         prev_ff  <= CH_NUL;
         seen_ff  <= 1'b0;
         held_ff  <= '0;
      end else if (dp_cmd.step) begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         seen_ff  <= seen_in;
         held_ff  <= held_in;
      end
   end

   // hold memory: one write port, one registered read port
   assign rd_en   = (dp_cmd.step && flush_needed) ||
                    (dp_cmd.flush_load && !dp_status.flush_last);
   assign rd_addr = dp_cmd.step ? '0 : flush_idx_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (dp_cmd.step && wr_en) begin
         hold_mem[held_ff[AW-1:0]] <= in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= hold_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.step && flush_needed) begin
         flush_idx_ff <= '0;
         flush_end_ff <= AW'(held_ff - CW'(1));
         pend_byte_ff <= in_byte;
      end else if (dp_cmd.flush_load) begin
         flush_idx_ff <= flush_idx_ff + AW'(1);
      end
   end

   // result register
   assign dp_status.out_free     = !rsp_valid_ff || rsp_tready;
   assign dp_status.flush_needed = flush_needed;
   assign dp_status.flush_last   = (flush_idx_ff == flush_end_ff);

   assign rsp_valid_in = (dp_cmd.step && single) || dp_cmd.flush_load || dp_cmd.last_load ||
                         (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.step && single) begin
         rsp_byte_ff    <= content_w ? in_byte : CH_NUL;
         rsp_kind_ff    <= phase_ff;
         rsp_content_ff <= content_w;
         rsp_end_ff     <= close_w && (status_w == ST_RUNNING);
         rsp_status_ff  <= status_w;
         rsp_last_ff    <= 1'b1;
      end else if (dp_cmd.flush_load) begin
         rsp_byte_ff    <= rd_data_ff;
         rsp_kind_ff    <= phase_ff;
         rsp_content_ff <= 1'b1;
         rsp_end_ff     <= 1'b0;
         rsp_status_ff  <= ST_RUNNING;
         rsp_last_ff    <= 1'b0;
      end else if (dp_cmd.last_load) begin
         rsp_byte_ff    <= pend_byte_ff;
         rsp_kind_ff    <= phase_ff;
         rsp_content_ff <= 1'b1;
         rsp_end_ff     <= 1'b0;
         rsp_status_ff  <= ST_RUNNING;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_byte    = rsp_byte_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_content = rsp_content_ff;
   assign rsp_end     = rsp_end_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

/* rtl/core/http_response_head_parser.sv */
// http_response_head_parser: tags version, status, reason and header bytes of a response head
// output: a byte that gives a single word has its result registered as the byte is accepted
// throughput: one byte per cycle when it gives at most one word and the output is not stalled;
//   a byte that flushes n held whitespace bytes gives n + 1 words, one word per cycle unless stalled
// reset: synchronous; clears parse phase, hold count, sequencer state and output valid, hold memory not cleared
// depends on hrhp_pkg, hrhp_ctrl, hrhp_datapath
module http_response_head_parser #(
   parameter int HOLD_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte[7:0]
   input  logic [0:0] req_tuser,   // conn_error[0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic [7:0] rsp_tuser,   // field_kind[2:0], is_content[3], field_end[4],
                                   // message_status[7:5]
   output logic       rsp_tlast
);
   import hrhp_pkg::*;

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_status;
   logic [2:0]    rsp_kind;
   logic          rsp_content;
   logic          rsp_end;
   logic [2:0]    rsp_status;

   hrhp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   hrhp_datapath #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_tdata),
      .conn_error  (req_tuser[0]),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_byte    (rsp_tdata),
      .rsp_kind    (rsp_kind),
      .rsp_content (rsp_content),
      .rsp_end     (rsp_end),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tuser = {rsp_status, rsp_end, rsp_content, rsp_kind};

endmodule
